[hdl/mlf_pkg.sv]
// Shared types and constants for the MAC learning and forwarding block.
// Used by every module in hdl/ except mlf_ram; depends on nothing else.
package mlf_pkg;

  // Frame header fields.
  localparam int unsigned MacW   = 48;
  localparam int unsigned PortW  = 4;
  localparam int unsigned MaskW  = 16;

  // Largest number of ports the switch supports; port_count is clamped to it.
  localparam int unsigned MaxPorts = 16;

  // Default number of entries in the address table.
  localparam int unsigned TableDepth = 64;

  // Configuration port geometry.
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned PortCntW  = 5;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegPortCount = 2'd0;
  localparam logic [1:0] RegLinked    = 2'd1;
  localparam logic [1:0] RegBlocked   = 2'd2;

  // Register reset values.
  localparam logic [PortCntW-1:0] PortCountRst = PortCntW'(16);

  // One frame header as it travels from the front queue to the back end.
  typedef struct packed {
    logic [MacW-1:0]  src_mac;
    logic [MacW-1:0]  dst_mac;
    logic [PortW-1:0] ingress;
    logic             same_mac;
  } item_t;

  // Switch configuration as seen by the back end.
  typedef struct packed {
    logic [PortCntW-1:0] port_count;
    logic [MaskW-1:0]    linked;
    logic [MaskW-1:0]    blocked;
  } cfg_t;

  // Handshake between the front queue and the back end.
  typedef struct packed {
    logic valid;
  } front_status_t;

endpackage

[hdl/mac_learning_forward.sv]
// Top level of the learning bridge forwarding decision.
// Depends on mlf_pkg, mlf_cfg, mlf_front, mlf_back and mlf_ram.
//
// Usage: a frame header word (source MAC, destination MAC, ingress port) is
// written with push while full is low. It waits in a two-word input queue.
// The back end takes one word at a time, reads every learned table entry
// through the single RAM read port, one entry per cycle, comparing it with
// both the source and the destination MAC, then learns the source with one
// RAM write unless it is new and the table is full, and forms the egress
// mask. The result word is held in an output register; it is valid while
// empty is low and is taken with pop. The time from push to result is set
// by the scan over the learned entries (at most TableDepth of them).
// While the receiver stalls, the finished result waits in the output
// register and up to two further headers are still accepted; one more can
// be in the scan before full stalls the sender.
// Reset empties the table (entry count zero), sets port_count to 16 and
// clears both port masks; the table RAM needs no clearing pass.
// Configuration registers sit at byte addresses 0, 4 and 8.
module mac_learning_forward
  import mlf_pkg::*;
#(
  parameter int unsigned TableDepth = mlf_pkg::TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Frame header input
  input  logic                push,
  output logic                full,
  input  logic [MacW-1:0]     source_mac_i,
  input  logic [MacW-1:0]     destination_mac_i,
  input  logic [PortW-1:0]    ingress_port_i,
  // Forwarding result
  output logic                empty,
  input  logic                pop,
  output logic [MaskW-1:0]    egress_mask_o,
  output logic                destination_known_o,
  output logic                source_was_new_o,
  output logic                table_full_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t          cfg;
  front_status_t front_status;
  item_t         item;
  logic          front_pop;

  // Configuration registers.
  mlf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input queue and classification.
  mlf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .source_mac_i      (source_mac_i),
    .destination_mac_i (destination_mac_i),
    .ingress_port_i    (ingress_port_i),
    .pop_i             (front_pop),
    .status_o          (front_status),
    .item_o            (item)
  );

  // Table scan, learning and forwarding decision.
  mlf_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .front_i             (front_status),
    .item_i              (item),
    .front_pop_o         (front_pop),
    .empty               (empty),
    .pop                 (pop),
    .egress_mask_o       (egress_mask_o),
    .destination_known_o (destination_known_o),
    .source_was_new_o    (source_was_new_o),
    .table_full_o        (table_full_o)
  );

endmodule

[hdl/mlf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module mlf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mlf_cfg.sv]
// APB-style configuration registers of the MAC learning and forwarding block.
// Depends on mlf_pkg.
module mlf_cfg
  import mlf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [PortCntW-1:0] port_count_q;
  logic [MaskW-1:0]    linked_q;
  logic [MaskW-1:0]    blocked_q;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_count_q <= PortCountRst;
      linked_q     <= '0;
      blocked_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegPortCount: port_count_q <= pwdata[PortCntW-1:0];
        RegLinked:    linked_q     <= pwdata[MaskW-1:0];
        RegBlocked:   blocked_q    <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      RegPortCount: prdata = CfgDataW'(port_count_q);
      RegLinked:    prdata = CfgDataW'(linked_q);
      RegBlocked:   prdata = CfgDataW'(blocked_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = '{port_count: port_count_q, linked: linked_q, blocked: blocked_q};

endmodule

[hdl/mlf_front.sv]
// Front end: accepts frame headers into a two-word queue and tags each one
// with whether its source and destination MACs are equal. Depends on mlf_pkg.
module mlf_front
  import mlf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [MacW-1:0]  source_mac_i,
  input  logic [MacW-1:0]  destination_mac_i,
  input  logic [PortW-1:0] ingress_port_i,
  input  logic             pop_i,
  output front_status_t    status_o,
  output item_t            item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;
  item_t      new_item;

  assign full     = (cnt_q == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop_i && (cnt_q != 2'd0);
  assign status_o = '{valid: (cnt_q != 2'd0)};
  assign item_o   = mem_q[rd_ptr_q];

  // Classify the incoming word.
  always_comb begin
    new_item.src_mac  = source_mac_i;
    new_item.dst_mac  = destination_mac_i;
    new_item.ingress  = ingress_port_i;
    new_item.same_mac = (source_mac_i == destination_mac_i);
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[hdl/mlf_back.sv]
// Back end: scans the address table for source and destination, learns the source
// if it fits, forms the egress mask and holds the result. Uses mlf_pkg, mlf_ram.
module mlf_back
  import mlf_pkg::*;
#(
  parameter int unsigned TableDepth = mlf_pkg::TableDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  front_status_t    front_i,
  input  item_t            item_i,
  output logic             front_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [MaskW-1:0] egress_mask_o,
  output logic             destination_known_o,
  output logic             source_was_new_o,
  output logic             table_full_o
);

  localparam int unsigned AddrW  = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);
  localparam int unsigned EntryW = MacW + PortW;

  typedef enum logic [1:0] {StIdle, StScan, StWrite, StResult} state_e;

  state_e             state_q, state_d;
  item_t              item_q, item_d;
  logic [CountW-1:0]  idx_q, idx_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               pend_q, pend_d;
  logic [AddrW-1:0]   pend_idx_q, pend_idx_d;
  logic               src_hit_q, src_hit_d;
  logic [AddrW-1:0]   src_slot_q, src_slot_d;
  logic               dst_hit_q, dst_hit_d;
  logic [PortW-1:0]   dst_port_q, dst_port_d;
  logic [MaskW-1:0]   res_mask_q, res_mask_d;
  logic               res_known_q, res_known_d;
  logic               res_new_q, res_new_d;
  logic               res_full_q, res_full_d;
  logic               out_valid_q, out_valid_d;
  logic [MaskW-1:0]   out_mask_q, out_mask_d;
  logic               out_known_q, out_known_d;
  logic               out_new_q, out_new_d;
  logic               out_full_q, out_full_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic               ram_re;
  logic [EntryW-1:0]  ram_rdata;
  logic [MacW-1:0]    rd_mac;
  logic [PortW-1:0]   rd_port;
  logic               has_room;
  logic               out_free;
  logic [PortCntW-1:0] n_ports;
  logic [MaskW-1:0]   in_use;
  logic [MaskW-1:0]   ingress_bit;
  logic [MaskW-1:0]   dest_bit;
  logic               dest_known;
  logic [PortW-1:0]   dest_port;

  // Address table: MAC in the low bits, port above it.
  mlf_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({item_q.ingress, item_q.src_mac}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_mac   = ram_rdata[MacW-1:0];
  assign rd_port  = ram_rdata[EntryW-1:MacW];
  assign has_room = (count_q < CountW'(TableDepth));
  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;

  assign front_pop_o = (state_q == StIdle) && front_i.valid;
  assign ram_re      = (state_q == StScan) && (idx_q < count_q);
  assign ram_we      = (state_q == StWrite) && (src_hit_q || has_room);
  assign ram_waddr   = src_hit_q ? src_slot_q : count_q[AddrW-1:0];

  // Ports in use: the lowest min(port_count, MaxPorts, MaskW).
  always_comb begin
    n_ports = cfg_i.port_count;
    if (n_ports > PortCntW'(MaxPorts)) begin
      n_ports = PortCntW'(MaxPorts);
    end
    if (n_ports > PortCntW'(MaskW)) begin
      n_ports = PortCntW'(MaskW);
    end
    for (int i = 0; i < MaskW; i++) begin
      in_use[i] = (PortCntW'(i) < n_ports);
    end
  end

  // Destination after learning: a same-MAC frame finds its own entry when it was written.
  always_comb begin
    if (item_q.same_mac) begin
      dest_known = src_hit_q || has_room;
      dest_port  = item_q.ingress;
    end else begin
      dest_known = dst_hit_q;
      dest_port  = dst_port_q;
    end
    ingress_bit = MaskW'(1) << item_q.ingress;
    dest_bit    = MaskW'(1) << dest_port;
  end

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    src_hit_d   = src_hit_q;
    src_slot_d  = src_slot_q;
    dst_hit_d   = dst_hit_q;
    dst_port_d  = dst_port_q;
    res_mask_d  = res_mask_q;
    res_known_d = res_known_q;
    res_new_d   = res_new_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q && !pop;
    out_mask_d  = out_mask_q;
    out_known_d = out_known_q;
    out_new_d   = out_new_q;
    out_full_d  = out_full_q;

    // Compare the entry read in the previous cycle.
    if (pend_q) begin
      if (!src_hit_q && rd_mac == item_q.src_mac) begin
        src_hit_d  = 1'b1;
        src_slot_d = pend_idx_q;
      end
      if (!dst_hit_q && rd_mac == item_q.dst_mac) begin
        dst_hit_d  = 1'b1;
        dst_port_d = rd_port;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (front_i.valid) begin
          item_d    = item_i;
          idx_d     = '0;
          src_hit_d = 1'b0;
          dst_hit_d = 1'b0;
          state_d   = StScan;
        end
      end
      StScan: begin
        if (idx_q < count_q) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[AddrW-1:0];
          idx_d      = idx_q + CountW'(1);
        end else if (!pend_q) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        res_new_d   = !src_hit_q && has_room;
        res_full_d  = !src_hit_q && !has_room;
        res_known_d = dest_known;
        if (dest_known) begin
          res_mask_d = (dest_port != item_q.ingress) ?
                       (dest_bit & in_use & cfg_i.linked) : '0;
        end else begin
          res_mask_d = cfg_i.linked & ~cfg_i.blocked & in_use & ~ingress_bit;
        end
        if (!src_hit_q && has_room) begin
          count_d = count_q + CountW'(1);
        end
        state_d = StResult;
      end
      StResult: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mask_d  = res_mask_q;
          out_known_d = res_known_q;
          out_new_d   = res_new_q;
          out_full_d  = res_full_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      item_q      <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      src_hit_q   <= 1'b0;
      src_slot_q  <= '0;
      dst_hit_q   <= 1'b0;
      dst_port_q  <= '0;
      res_mask_q  <= '0;
      res_known_q <= 1'b0;
      res_new_q   <= 1'b0;
      res_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_known_q <= 1'b0;
      out_new_q   <= 1'b0;
      out_full_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      src_hit_q   <= src_hit_d;
      src_slot_q  <= src_slot_d;
      dst_hit_q   <= dst_hit_d;
      dst_port_q  <= dst_port_d;
      res_mask_q  <= res_mask_d;
      res_known_q <= res_known_d;
      res_new_q   <= res_new_d;
      res_full_q  <= res_full_d;
      out_valid_q <= out_valid_d;
      out_mask_q  <= out_mask_d;
      out_known_q <= out_known_d;
      out_new_q   <= out_new_d;
      out_full_q  <= out_full_d;
    end
  end

  assign egress_mask_o       = out_mask_q;
  assign destination_known_o = out_known_q;
  assign source_was_new_o    = out_new_q;
  assign table_full_o        = out_full_q;

endmodule
